// ----- hdl/atp_pkg.sv -----
// ----------------------------------------------------------------------------
// atp_pkg
// Shared widths, fixed-point constants and the pipeline side-band type for
// the four-quadrant arctangent pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

    localparam int INPUT_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

    localparam int RATIO_FRAC = 16;
    localparam int COEF_FRAC  = 30;

    // magnitude of the most negative input needs the full input width
    localparam int MAG_W   = INPUT_WIDTH;
    localparam int NUM_W   = INPUT_WIDTH + RATIO_FRAC;
    localparam int RATIO_W = RATIO_FRAC + 1;
    localparam int SQ_W    = 2 * RATIO_W;

    localparam int DIV_STAGES = RATIO_W;

    localparam int ACC_W  = COEF_FRAC + 2;
    localparam int PROD_W = ACC_W + RATIO_W + 1;
    localparam int T_W    = COEF_FRAC + 4;

    localparam int POLY_TERMS   = 7;
    localparam int HORNER_STEPS = POLY_TERMS - 1;

    localparam int ROUND_SHIFT = COEF_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] POLY_COEF [0:POLY_TERMS-1] = '{
        ACC_W'(64'sd7744777),
        ACC_W'(-64'sd37645046),
        ACC_W'(64'sd87698811),
        ACC_W'(-64'sd143609290),
        ACC_W'(64'sd213208227),
        ACC_W'(-64'sd357824448),
        ACC_W'(64'sd1073741824)
    };

    localparam longint PI_Q30_L      = 64'sd3373259426;
    localparam longint HALF_PI_Q30_L = 64'sd1686629713;

    localparam logic signed [T_W-1:0] PI_Q30      = T_W'(PI_Q30_L);
    localparam logic signed [T_W-1:0] HALF_PI_Q30 = T_W'(HALF_PI_Q30_L);

    // pi at the output scale, used for range checks
    localparam int ANGLE_PI =
        int'((PI_Q30_L + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);

    typedef struct packed {
        logic ybig;
        logic xneg;
        logic yneg;
        logic zero;
    } side_t;

endpackage

// ----- hdl/atp_front.sv -----
// ----------------------------------------------------------------------------
// atp_front
// Two pipeline stages: absolute values, then ordering of the magnitudes and
// forming of the rounded dividend and divisor for the ratio.
// ----------------------------------------------------------------------------
module atp_front import atp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   v_in,
    input  logic [INPUT_WIDTH-1:0] x_coord,
    input  logic [INPUT_WIDTH-1:0] y_coord,
    output logic                   v_out,
    output side_t                  side_out,
    output logic [NUM_W-1:0]       num_out,
    output logic [MAG_W-1:0]       den_out
);

    logic             v1_reg;
    logic [MAG_W-1:0] ax_reg;
    logic [MAG_W-1:0] ay_reg;
    logic             xneg_reg;
    logic             yneg_reg;
    logic [MAG_W-1:0] ax_next;
    logic [MAG_W-1:0] ay_next;

    logic             v2_reg;
    side_t            side_reg;
    logic [NUM_W-1:0] num_reg;
    logic [MAG_W-1:0] den_reg;
    side_t            side_next;
    logic [NUM_W-1:0] num_next;
    logic [MAG_W-1:0] mx_c;
    logic [MAG_W-1:0] mn_c;

    // exact magnitude: the most negative code maps to its unsigned value
    assign ax_next = x_coord[INPUT_WIDTH-1] ? MAG_W'(~x_coord + 1'b1) : MAG_W'(x_coord);
    assign ay_next = y_coord[INPUT_WIDTH-1] ? MAG_W'(~y_coord + 1'b1) : MAG_W'(y_coord);

    always_comb
    begin
        side_next.ybig = ay_reg > ax_reg;
        side_next.xneg = xneg_reg;
        side_next.yneg = yneg_reg;
        mx_c           = side_next.ybig ? ay_reg : ax_reg;
        mn_c           = side_next.ybig ? ax_reg : ay_reg;
        side_next.zero = (mx_c == '0);
        // add half the divisor so that truncating division rounds halves up
        num_next       = NUM_W'({mn_c, {RATIO_FRAC{1'b0}}}) + NUM_W'(mx_c >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            xneg_reg <= x_coord[INPUT_WIDTH-1];
            yneg_reg <= y_coord[INPUT_WIDTH-1];
            side_reg <= side_next;
            num_reg  <= num_next;
            den_reg  <= mx_c;
        end
    end

    assign v_out    = v2_reg;
    assign side_out = side_reg;
    assign num_out  = num_reg;
    assign den_out  = den_reg;

endmodule

// ----- hdl/atp_div_stage.sv -----
// ----------------------------------------------------------------------------
// atp_div_stage
// One registered step of the restoring divider: one quotient bit per stage.
// The low word shifts dividend bits out and quotient bits in.
// ----------------------------------------------------------------------------
module atp_div_stage import atp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               v_in,
    input  side_t              side_in,
    input  logic [MAG_W-1:0]   den_in,
    input  logic [MAG_W-1:0]   rem_in,
    input  logic [RATIO_W-1:0] quo_in,
    output logic               v_out,
    output side_t              side_out,
    output logic [MAG_W-1:0]   den_out,
    output logic [MAG_W-1:0]   rem_out,
    output logic [RATIO_W-1:0] quo_out
);

    logic               v_reg;
    side_t              side_reg;
    logic [MAG_W-1:0]   den_reg;
    logic [MAG_W-1:0]   rem_reg;
    logic [RATIO_W-1:0] quo_reg;

    logic [MAG_W:0]     shifted_c;
    logic [MAG_W:0]     diff_c;
    logic               ge_c;
    logic [MAG_W-1:0]   rem_next;
    logic [RATIO_W-1:0] quo_next;

    always_comb
    begin
        shifted_c = {rem_in, quo_in[RATIO_W-1]};
        diff_c    = shifted_c - {1'b0, den_in};
        ge_c      = shifted_c >= {1'b0, den_in};
        rem_next  = ge_c ? diff_c[MAG_W-1:0] : shifted_c[MAG_W-1:0];
        quo_next  = {quo_in[RATIO_W-2:0], ge_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign v_out    = v_reg;
    assign side_out = side_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;

endmodule

// ----- hdl/atp_horner_cell.sv -----
// ----------------------------------------------------------------------------
// atp_horner_cell
// One Horner step over two stages: multiply the accumulator by the squared
// ratio, then round off the ratio scale and add the next coefficient.
// ----------------------------------------------------------------------------
module atp_horner_cell import atp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    v_in,
    input  side_t                   side_in,
    input  logic [RATIO_W-1:0]      r_in,
    input  logic [RATIO_W-1:0]      s_in,
    input  logic signed [ACC_W-1:0] acc_in,
    input  logic signed [ACC_W-1:0] coef,
    output logic                    v_out,
    output side_t                   side_out,
    output logic [RATIO_W-1:0]      r_out,
    output logic [RATIO_W-1:0]      s_out,
    output logic signed [ACC_W-1:0] acc_out
);

    logic                     va_reg;
    side_t                    side_a_reg;
    logic [RATIO_W-1:0]       r_a_reg;
    logic [RATIO_W-1:0]       s_a_reg;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic                     vb_reg;
    side_t                    side_b_reg;
    logic [RATIO_W-1:0]       r_b_reg;
    logic [RATIO_W-1:0]       s_b_reg;
    logic signed [ACC_W-1:0]  acc_b_reg;
    logic signed [PROD_W-1:0] rnd_c;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod_next = PROD_W'(acc_in) * PROD_W'($signed({1'b0, s_in}));

    always_comb
    begin
        rnd_c    = prod_a_reg + PROD_W'(2 ** (RATIO_FRAC - 1));
        // arithmetic shift by slicing: floor of the rounded product
        acc_next = $signed(rnd_c[RATIO_FRAC +: ACC_W]) + coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= v_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= side_in;
            r_a_reg    <= r_in;
            s_a_reg    <= s_in;
            prod_a_reg <= prod_next;
            side_b_reg <= side_a_reg;
            r_b_reg    <= r_a_reg;
            s_b_reg    <= s_a_reg;
            acc_b_reg  <= acc_next;
        end
    end

    assign v_out    = vb_reg;
    assign side_out = side_b_reg;
    assign r_out    = r_b_reg;
    assign s_out    = s_b_reg;
    assign acc_out  = acc_b_reg;

endmodule

// ----- hdl/atp_back.sv -----
// ----------------------------------------------------------------------------
// atp_back
// Four stages: scale the polynomial by the ratio, round to the base angle,
// reflect into the octant and quadrant, then round and apply the sign.
// ----------------------------------------------------------------------------
module atp_back import atp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    v_in,
    input  side_t                   side_in,
    input  logic [RATIO_W-1:0]      r_in,
    input  logic signed [ACC_W-1:0] acc_in,
    output logic                    v_out,
    output logic [ANGLE_WIDTH-1:0]  angle_out
);

    logic [3:0]               v_reg;
    side_t                    side1_reg;
    side_t                    side2_reg;
    side_t                    side3_reg;
    logic signed [PROD_W-1:0] tp_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [T_W-1:0]    tr_reg;
    logic [ANGLE_WIDTH-1:0]   angle_reg;

    logic signed [PROD_W-1:0] tp_next;
    logic signed [PROD_W-1:0] trnd_c;
    logic signed [T_W-1:0]    t_next;
    logic signed [T_W-1:0]    oct_c;
    logic signed [T_W-1:0]    quad_c;
    logic signed [T_W-1:0]    tr_next;
    logic [T_W-1:0]           mrnd_c;
    logic [ANGLE_WIDTH-1:0]   mag_c;
    logic [ANGLE_WIDTH-1:0]   angle_next;

    assign tp_next = PROD_W'(acc_in) * PROD_W'($signed({1'b0, r_in}));

    always_comb
    begin
        trnd_c = tp_reg + PROD_W'(2 ** (RATIO_FRAC - 1));
        t_next = $signed(trnd_c[RATIO_FRAC +: T_W]);

        oct_c   = side2_reg.ybig ? (HALF_PI_Q30 - t_reg) : t_reg;
        quad_c  = side2_reg.xneg ? (PI_Q30 - oct_c) : oct_c;
        tr_next = quad_c[T_W-1] ? '0 : quad_c;

        mrnd_c = T_W'(tr_reg) + T_W'(2 ** (ROUND_SHIFT - 1));
        mag_c  = mrnd_c[ROUND_SHIFT +: ANGLE_WIDTH];
        if (side3_reg.zero)
        begin
            angle_next = '0;
        end
        else if (side3_reg.yneg)
        begin
            angle_next = ~mag_c + 1'b1;
        end
        else
        begin
            angle_next = mag_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            tp_reg    <= tp_next;
            t_reg     <= t_next;
            tr_reg    <= tr_next;
            angle_reg <= angle_next;
        end
    end

    assign v_out     = v_reg[3];
    assign angle_out = angle_reg;

endmodule

// ----- hdl/atan2_polynomial.sv -----
// ----------------------------------------------------------------------------
// atan2_polynomial
// Stages from the input to the output register: 2 front stages, 17 divider stages
// (one ratio bit each), 2 squaring stages, 12 Horner stages, 4 back-end stages,
// 1 output register. Throughput: one vector per cycle while vec_stall is low;
// a two-entry output buffer absorbs stalls.
// Reset clears all valid bits and the output buffer; data registers are not reset.
// ----------------------------------------------------------------------------
module atan2_polynomial import atp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vec_valid,
    output logic                   vec_stall,
    input  logic [INPUT_WIDTH-1:0] x_coord,
    input  logic [INPUT_WIDTH-1:0] y_coord,
    output logic                   angle_valid,
    input  logic                   angle_stall,
    output logic [ANGLE_WIDTH-1:0] angle
);

    logic adv;

    logic             front_v;
    side_t            front_side;
    logic [NUM_W-1:0] front_num;
    logic [MAG_W-1:0] front_den;

    logic               div_v    [0:DIV_STAGES];
    side_t              div_side [0:DIV_STAGES];
    logic [MAG_W-1:0]   div_den  [0:DIV_STAGES];
    logic [MAG_W-1:0]   div_rem  [0:DIV_STAGES];
    logic [RATIO_W-1:0] div_quo  [0:DIV_STAGES];

    logic               sq1_v_reg;
    side_t              sq1_side_reg;
    logic [RATIO_W-1:0] sq1_r_reg;
    logic [SQ_W-1:0]    sq1_prod_reg;
    logic               sq2_v_reg;
    side_t              sq2_side_reg;
    logic [RATIO_W-1:0] sq2_r_reg;
    logic [RATIO_W-1:0] sq2_s_reg;
    logic [SQ_W-1:0]    sq_rnd_c;

    logic                    hc_v    [0:HORNER_STEPS];
    side_t                   hc_side [0:HORNER_STEPS];
    logic [RATIO_W-1:0]      hc_r    [0:HORNER_STEPS];
    logic [RATIO_W-1:0]      hc_s    [0:HORNER_STEPS];
    logic signed [ACC_W-1:0] hc_acc  [0:HORNER_STEPS];

    logic                   pipe_v;
    logic [ANGLE_WIDTH-1:0] pipe_angle;

    logic                   out_v_reg;
    logic [ANGLE_WIDTH-1:0] out_angle_reg;
    logic                   skid_v_reg;
    logic [ANGLE_WIDTH-1:0] skid_angle_reg;
    logic                   out_load;

    // the whole pipeline advances while the skid entry is free
    assign adv       = !skid_v_reg;
    assign vec_stall = skid_v_reg;

    atp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .v_in     (vec_valid),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .v_out    (front_v),
        .side_out (front_side),
        .num_out  (front_num),
        .den_out  (front_den)
    );

    assign div_v[0]    = front_v;
    assign div_side[0] = front_side;
    assign div_den[0]  = front_den;
    assign div_rem[0]  = MAG_W'(front_num[NUM_W-1:RATIO_W]);
    assign div_quo[0]  = front_num[RATIO_W-1:0];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        atp_div_stage u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .v_in     (div_v[i]),
            .side_in  (div_side[i]),
            .den_in   (div_den[i]),
            .rem_in   (div_rem[i]),
            .quo_in   (div_quo[i]),
            .v_out    (div_v[i+1]),
            .side_out (div_side[i+1]),
            .den_out  (div_den[i+1]),
            .rem_out  (div_rem[i+1]),
            .quo_out  (div_quo[i+1])
        );
    end

    // square of the ratio, rounded back to the ratio scale
    assign sq_rnd_c = sq1_prod_reg + SQ_W'(2 ** (RATIO_FRAC - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq1_v_reg <= 1'b0;
            sq2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq1_v_reg <= div_v[DIV_STAGES];
            sq2_v_reg <= sq1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_side_reg <= div_side[DIV_STAGES];
            sq1_r_reg    <= div_quo[DIV_STAGES];
            sq1_prod_reg <= SQ_W'(div_quo[DIV_STAGES]) * SQ_W'(div_quo[DIV_STAGES]);
            sq2_side_reg <= sq1_side_reg;
            sq2_r_reg    <= sq1_r_reg;
            sq2_s_reg    <= sq_rnd_c[RATIO_FRAC +: RATIO_W];
        end
    end

    assign hc_v[0]    = sq2_v_reg;
    assign hc_side[0] = sq2_side_reg;
    assign hc_r[0]    = sq2_r_reg;
    assign hc_s[0]    = sq2_s_reg;
    assign hc_acc[0]  = POLY_COEF[0];

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        atp_horner_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .v_in     (hc_v[k]),
            .side_in  (hc_side[k]),
            .r_in     (hc_r[k]),
            .s_in     (hc_s[k]),
            .acc_in   (hc_acc[k]),
            .coef     (POLY_COEF[k+1]),
            .v_out    (hc_v[k+1]),
            .side_out (hc_side[k+1]),
            .r_out    (hc_r[k+1]),
            .s_out    (hc_s[k+1]),
            .acc_out  (hc_acc[k+1])
        );
    end

    atp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .v_in      (hc_v[HORNER_STEPS]),
        .side_in   (hc_side[HORNER_STEPS]),
        .r_in      (hc_r[HORNER_STEPS]),
        .acc_in    (hc_acc[HORNER_STEPS]),
        .v_out     (pipe_v),
        .angle_out (pipe_angle)
    );

    // output register is free or being taken
    assign out_load = !out_v_reg || !angle_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_v_reg  <= skid_v_reg || (pipe_v && adv);
            skid_v_reg <= 1'b0;
        end
        else if (pipe_v && adv)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_angle_reg <= skid_v_reg ? skid_angle_reg : pipe_angle;
        end
        else if (pipe_v && adv)
        begin
            skid_angle_reg <= pipe_angle;
        end
    end

    assign angle_valid = out_v_reg;
    assign angle       = out_angle_reg;

endmodule

// ----- hdl/atp_checker.sv -----
// ----------------------------------------------------------------------------
// atp_checker
// Port-level checks on the arctangent pipeline: output hold under stall,
// angle range and the behaviour of the input stall against the output side.
// ----------------------------------------------------------------------------
module atp_checker import atp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   vec_stall,
    input logic                   angle_valid,
    input logic                   angle_stall,
    input logic [ANGLE_WIDTH-1:0] angle
);

    localparam logic signed [ANGLE_WIDTH-1:0] PI_LIM = ANGLE_WIDTH'(ANGLE_PI);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall |=> angle_valid && $stable(angle))
    else $error("stalled angle beat changed or dropped");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> ($signed(angle) <= PI_LIM) && ($signed(angle) >= -PI_LIM))
    else $error("angle outside minus pi to plus pi");

    // input stalls only while a result waits at the output
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        vec_stall |-> angle_valid)
    else $error("input stalled with no result pending");

    // drain the buffer as soon as the output side takes a beat
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        !angle_stall |=> !vec_stall)
    else $error("input stall held after output was free");

endmodule

bind atan2_polynomial atp_checker u_atp_checker (.*);
